[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, codes and command/status bundles for the binary max-heap
// priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 7;
  localparam int STATUS_W         = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped_value;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic start_push;
    logic start_pop;
    logic set_full;
    logic set_empty;
    logic take_pop;
    logic rd_up;
    logic rd_down;
    logic move_up;
    logic move_down;
    logic place;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic pos_zero;
    logic l_valid;
    logic up_swap;
    logic down_swap;
  } dp_stat_t;

endpackage

[rtl/bmhq_datapath.sv]
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap store with two registered read ports and one write port, hole position,
// moving value, entry count and the result register.
// ----------------------------------------------------------------------------
module bmhq_datapath import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output rsp_t     rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  logic [CW-1:0]             cnt;
  logic [AW-1:0]             pos;
  logic signed [VALUE_W-1:0] val;
  logic signed [VALUE_W-1:0] popped;
  logic [STATUS_W-1:0]       status_w;
  logic signed [VALUE_W-1:0] rd_a;
  logic signed [VALUE_W-1:0] rd_b;

  logic [IW-1:0]             l_idx;
  logic [IW-1:0]             r_idx;
  logic [IW-1:0]             n_ext;
  logic [AW-1:0]             parent;
  logic [AW-1:0]             last;
  logic [AW-1:0]             addr_a;
  logic [AW-1:0]             addr_b;
  logic                      wr_en;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      r_valid;
  logic                      r_gt_l;
  logic signed [VALUE_W-1:0] child;
  logic [AW-1:0]             child_idx;

  assign l_idx   = {1'b0, pos, 1'b1};
  assign r_idx   = l_idx + IW'(1);
  assign n_ext   = IW'(cnt);
  assign parent  = (pos - AW'(1)) >> 1;
  assign last    = AW'(cnt - CW'(1));
  assign r_valid = r_idx < n_ext;

  // larger child, left wins a tie
  assign r_gt_l    = r_valid && (rd_b > rd_a);
  assign child     = r_gt_l ? rd_b : rd_a;
  assign child_idx = r_gt_l ? r_idx[AW-1:0] : l_idx[AW-1:0];

  assign stat.cnt_zero  = (cnt == '0);
  assign stat.cnt_full  = (cnt == CW'(CAPACITY));
  assign stat.pos_zero  = (pos == '0);
  assign stat.l_valid   = l_idx < n_ext;
  assign stat.up_swap   = val > rd_a;
  assign stat.down_swap = child > val;

  always_comb begin
    priority if (cmd.start_pop) begin
      addr_a = '0;
    end else if (cmd.rd_up) begin
      addr_a = parent;
    end else begin
      addr_a = l_idx[AW-1:0];
    end
  end

  assign addr_b  = cmd.start_pop ? last : r_idx[AW-1:0];
  assign wr_en   = cmd.place | cmd.move_up | cmd.move_down;
  assign wr_data = cmd.move_up ? rd_a : (cmd.move_down ? child : val);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start_push) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.start_pop) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_push) begin
      val      <= req.value;
      pos      <= cnt[AW-1:0];
      status_w <= ST_OK;
      popped   <= '0;
    end
    if (cmd.start_pop) begin
      pos      <= '0;
      status_w <= ST_OK;
    end
    if (cmd.take_pop) begin
      // last entry becomes the value to sift down
      val    <= rd_b;
      popped <= rd_a;
    end
    if (cmd.set_full) begin
      status_w <= ST_FULL;
      popped   <= '0;
    end
    if (cmd.set_empty) begin
      status_w <= ST_EMPTY;
      popped   <= '0;
    end
    if (cmd.move_up) begin
      pos <= parent;
    end
    if (cmd.move_down) begin
      pos <= child_idx;
    end
    if (cmd.load_out) begin
      rsp.status       <= status_w;
      rsp.popped_value <= popped;
      rsp.count        <= COUNT_W'(cnt);
    end
  end

endmodule

[rtl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for push sift-up and pop sift-down, plus the result handshake.
// ----------------------------------------------------------------------------
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_op,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output logic     req_ready,
  output logic     rsp_valid,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CHK   = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_POP_TAKE = 4'd3;
  localparam logic [3:0] S_DN_CHK   = 4'd4;
  localparam logic [3:0] S_DN_CMP   = 4'd5;
  localparam logic [3:0] S_FIN      = 4'd6;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_op == OP_POP) begin
            if (stat.cnt_zero) begin
              cmd.set_empty = 1'b1;
              state_next    = S_FIN;
            end else begin
              cmd.start_pop = 1'b1;
              state_next    = S_POP_TAKE;
            end
          end else begin
            if (stat.cnt_full) begin
              cmd.set_full = 1'b1;
              state_next   = S_FIN;
            end else begin
              cmd.start_push = 1'b1;
              state_next     = S_UP_CHK;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_up  = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_swap) begin
          cmd.move_up = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_POP_TAKE: begin
        cmd.take_pop = 1'b1;
        state_next   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.l_valid) begin
          cmd.rd_down = 1'b1;
          state_next  = S_DN_CMP;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_DN_CMP: begin
        if (stat.down_swap) begin
          cmd.move_down = 1'b1;
          state_next    = S_DN_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Each heap level takes a registered store read, then a compare and write.
// One word in flight; the next is accepted after the result is registered,
// even while that result still waits. Synchronous reset empties the queue;
// store contents are not cleared.
// ----------------------------------------------------------------------------
module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .cmd       (cmd)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

[rtl/bmhq_checker.sv]
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks on result words of the heap queue, bound to the top.
// ----------------------------------------------------------------------------
module bmhq_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_EMPTY ||
                   rsp.status == ST_FULL))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == '0)
    else $error("failed operation returned a value");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.count == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

endmodule

bind binary_max_heap_queue bmhq_checker #(
  .CAPACITY (CAPACITY)
) u_bmhq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
